// File: hdl/aspba_pkg.sv
// ----------------------------------------------------------------------------
// aspba_pkg
// Shared types and constants of the accelerometer scale, peak and block
// average block.
// ----------------------------------------------------------------------------
package aspba_pkg;

	localparam int BLOCK_LENGTH_DEF = 500;
	localparam int QUEUE_DEPTH      = 4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 22;

	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 2'd2;

	localparam logic [4:0]         FULL_SCALE_RESET = 5'd2;
	localparam logic [4:0]         FULL_SCALE_MAX   = 5'd16;
	localparam logic [17:0]        GAIN_RESET       = 18'd65536;
	localparam logic [21:0]        RAD_TO_DEG_Q16   = 22'd3754937;
	localparam logic [24:0]        ACCEL_LIMIT      = 25'd4194304;
	localparam int                 ROUND_HALF       = 32768;

	typedef struct packed {
		logic signed [23:0] corr;
		logic signed [21:0] scaled;
	} mid_item_t;

	typedef struct packed {
		logic signed [23:0] accel_g;
		logic signed [28:0] angle_deg;
		logic        [22:0] peak_abs_g;
		logic        [23:0] peak_change_g;
		logic signed [23:0] average_g;
		logic signed [21:0] raw_average_g;
		logic               block_done;
	} out_item_t;

	typedef struct packed {
		logic               ready;
		logic signed [23:0] avg_c;
		logic signed [21:0] avg_r;
	} div_stat_t;

endpackage

// File: hdl/aspba_fifo.sv
// ----------------------------------------------------------------------------
// aspba_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module aspba_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// File: hdl/aspba_front.sv
// ----------------------------------------------------------------------------
// aspba_front
// Configuration registers and the scaling pipeline: full-scale multiply and
// offset, gain multiply, rounding and saturation into the middle queue.
// ----------------------------------------------------------------------------
module aspba_front import aspba_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  logic signed [15:0]    raw_sample,
	output logic                  mid_push,
	output mid_item_t             mid_data,
	input  logic                  mid_full
);

	logic [4:0]         full_scale_q;
	logic signed [21:0] offset_q;
	logic [17:0]        gain_q;

	logic               en;
	logic               take;
	logic [4:0]         fs_eff;
	logic signed [21:0] raw_ext, fs_ext, fs_prod, scaled;
	logic signed [22:0] diff;

	logic               v_s1, v_s2, v_s3;
	logic signed [22:0] diff_s1;
	logic signed [21:0] scaled_s1, scaled_s2, scaled_s3;
	logic signed [40:0] prod_s2;
	logic signed [23:0] corr_s3;

	logic               neg;
	logic [40:0]        mag;
	logic [24:0]        q, q_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= FULL_SCALE_RESET;
			offset_q     <= '0;
			gain_q       <= GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FULL_SCALE: full_scale_q <= cfg_data[4:0];
				REG_OFFSET:     offset_q     <= $signed(cfg_data);
				REG_GAIN:       gain_q       <= cfg_data[17:0];
				default: begin
				end
			endcase
		end
	end

	// pipeline stalls as a whole when the last stage cannot drain
	assign en   = !v_s3 || !mid_full;
	assign full = !en;
	assign take = push && en;

	assign fs_eff  = (full_scale_q > FULL_SCALE_MAX) ? FULL_SCALE_MAX : full_scale_q;
	assign raw_ext = 22'(raw_sample);
	assign fs_ext  = $signed(22'(fs_eff));
	assign fs_prod = raw_ext * fs_ext;
	assign scaled  = {fs_prod[20:0], 1'b0};
	assign diff    = 23'(scaled) - 23'(offset_q);

	assign neg   = prod_s2[40];
	assign mag   = neg ? 41'(-prod_s2) : 41'(prod_s2);
	assign q     = 25'((mag + 41'(ROUND_HALF)) >> 16);
	assign q_sat = (q > ACCEL_LIMIT) ? ACCEL_LIMIT : q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1   <= diff;
			scaled_s1 <= scaled;
			prod_s2   <= diff_s1 * $signed({1'b0, gain_q});
			scaled_s2 <= scaled_s1;
			corr_s3   <= neg ? -24'(q_sat) : 24'(q_sat);
			scaled_s3 <= scaled_s2;
		end
	end

	assign mid_push        = v_s3 && !mid_full;
	assign mid_data.corr   = corr_s3;
	assign mid_data.scaled = scaled_s3;

endmodule

// File: hdl/aspba_div.sv
// ----------------------------------------------------------------------------
// aspba_div
// Rounding divider of both block sums by the block length: each magnitude is
// multiplied by a scaled reciprocal in two registered steps.
// ----------------------------------------------------------------------------
module aspba_div import aspba_pkg::*; #(
	parameter int BLOCK_LENGTH = BLOCK_LENGTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [24+$clog2(BLOCK_LENGTH)-1:0] sum_c,
	input  logic signed [22+$clog2(BLOCK_LENGTH)-1:0] sum_r,
	output div_stat_t                             stat
);

	localparam int CW     = $clog2(BLOCK_LENGTH);
	localparam int SUMC_W = 24 + CW;
	localparam int SUMR_W = 22 + CW;
	localparam int NUM_W  = 32;
	localparam int SH     = NUM_W + CW;

	// ceil(2^SH / BLOCK_LENGTH), exact floor quotient for any 32-bit numerator
	localparam logic [63:0] RECIP    = ((64'd1 << SH) + 64'(BLOCK_LENGTH) - 64'd1) /
		64'(BLOCK_LENGTH);
	localparam logic [16:0] RECIP_LO = RECIP[16:0];
	localparam logic [15:0] RECIP_HI = RECIP[32:17];

	logic                v_s1, v_s2;
	logic [NUM_W-1:0]    num_c_s1, num_r_s1;
	logic                neg_c_s1, neg_r_s1;
	logic [48:0]         lo_c_s2, lo_r_s2;
	logic [47:0]         hi_c_s2, hi_r_s2;
	logic                neg_c_s2, neg_r_s2;
	logic                ready_q;
	logic signed [23:0]  avg_c_q;
	logic signed [21:0]  avg_r_q;

	logic [SUMC_W-1:0]   mag_c;
	logic [SUMR_W-1:0]   mag_r;
	logic [64:0]         prod_c, prod_r;
	logic [23:0]         quo_c;
	logic [21:0]         quo_r;

	assign mag_c = sum_c[SUMC_W-1] ? SUMC_W'(-sum_c) : SUMC_W'(sum_c);
	assign mag_r = sum_r[SUMR_W-1] ? SUMR_W'(-sum_r) : SUMR_W'(sum_r);

	assign prod_c = {hi_c_s2, 17'b0} + 65'(lo_c_s2);
	assign prod_r = {hi_r_s2, 17'b0} + 65'(lo_r_s2);
	assign quo_c  = 24'(prod_c >> SH);
	assign quo_r  = 22'(prod_r >> SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			ready_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			if (start) begin
				ready_q <= 1'b0;
			end else if (v_s2) begin
				ready_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_c_s1 <= NUM_W'(mag_c) + NUM_W'(BLOCK_LENGTH / 2);
			num_r_s1 <= NUM_W'(mag_r) + NUM_W'(BLOCK_LENGTH / 2);
			neg_c_s1 <= sum_c[SUMC_W-1];
			neg_r_s1 <= sum_r[SUMR_W-1];
		end
		if (v_s1) begin
			lo_c_s2  <= num_c_s1 * RECIP_LO;
			hi_c_s2  <= num_c_s1 * RECIP_HI;
			lo_r_s2  <= num_r_s1 * RECIP_LO;
			hi_r_s2  <= num_r_s1 * RECIP_HI;
			neg_c_s2 <= neg_c_s1;
			neg_r_s2 <= neg_r_s1;
		end
		if (v_s2) begin
			avg_c_q <= neg_c_s2 ? -$signed(quo_c) : $signed(quo_c);
			avg_r_q <= neg_r_s2 ? -$signed(quo_r) : $signed(quo_r);
		end
	end

	assign stat.ready = ready_q;
	assign stat.avg_c = avg_c_q;
	assign stat.avg_r = avg_r_q;

endmodule

// File: hdl/aspba_back.sv
// ----------------------------------------------------------------------------
// aspba_back
// Angle multiply, peak tracking, block sums and held averages; assembles the
// result and writes it into the output queue.
// ----------------------------------------------------------------------------
module aspba_back import aspba_pkg::*; #(
	parameter int BLOCK_LENGTH = BLOCK_LENGTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      mid_empty,
	input  mid_item_t mid_data,
	output logic      mid_pop,
	output logic      out_push,
	output out_item_t out_data,
	input  logic      out_full
);

	localparam int CW     = $clog2(BLOCK_LENGTH);
	localparam int SUMC_W = 24 + CW;
	localparam int SUMR_W = 22 + CW;

	logic signed [23:0]     prev_q;
	logic                   have_prev_q;
	logic [22:0]            peak_abs_q;
	logic [23:0]            peak_chg_q;
	logic [CW-1:0]          cnt_q;
	logic signed [SUMC_W-1:0] sum_c_q;
	logic signed [SUMR_W-1:0] sum_r_q;
	logic signed [23:0]     held_c_q;
	logic signed [21:0]     held_r_q;

	logic                   v_s1;
	logic signed [23:0]     corr_s1;
	logic signed [45:0]     aprod_s1;
	logic [22:0]            peak_abs_s1;
	logic [23:0]            peak_chg_s1;
	logic                   done_s1;

	logic                   drain;
	logic                   last;
	logic [22:0]            mag, pk_new;
	logic signed [24:0]     delta;
	logic [23:0]            dmag, pd_new;
	logic signed [SUMC_W-1:0] sum_c_new;
	logic signed [SUMR_W-1:0] sum_r_new;
	logic                   a_neg;
	logic [45:0]            a_mag;
	logic [29:0]            a_q;
	div_stat_t              stat;

	assign drain   = v_s1 && !out_full && (!done_s1 || stat.ready);
	assign mid_pop = !mid_empty && (!v_s1 || drain);

	assign last   = (cnt_q == CW'(BLOCK_LENGTH - 1));
	assign mag    = mid_data.corr[23] ? 23'(-mid_data.corr) : 23'(mid_data.corr);
	assign pk_new = (mag > peak_abs_q) ? mag : peak_abs_q;
	assign delta  = 25'(mid_data.corr) - 25'(prev_q);
	assign dmag   = delta[24] ? 24'(-delta) : 24'(delta);
	assign pd_new = (have_prev_q && dmag > peak_chg_q) ? dmag : peak_chg_q;

	assign sum_c_new = sum_c_q + SUMC_W'(mid_data.corr);
	assign sum_r_new = sum_r_q + SUMR_W'(mid_data.scaled);

	aspba_div #(
		.BLOCK_LENGTH(BLOCK_LENGTH)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mid_pop && last),
		.sum_c (sum_c_new),
		.sum_r (sum_r_new),
		.stat  (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			peak_abs_q  <= '0;
			peak_chg_q  <= '0;
			cnt_q       <= '0;
			sum_c_q     <= '0;
			sum_r_q     <= '0;
			held_c_q    <= '0;
			held_r_q    <= '0;
			v_s1        <= 1'b0;
		end else begin
			if (mid_pop) begin
				prev_q      <= mid_data.corr;
				have_prev_q <= 1'b1;
				peak_abs_q  <= pk_new;
				peak_chg_q  <= pd_new;
				if (last) begin
					cnt_q   <= '0;
					sum_c_q <= '0;
					sum_r_q <= '0;
				end else begin
					cnt_q   <= cnt_q + 1'b1;
					sum_c_q <= sum_c_new;
					sum_r_q <= sum_r_new;
				end
			end
			if (drain && done_s1) begin
				held_c_q <= stat.avg_c;
				held_r_q <= stat.avg_r;
			end
			if (mid_pop) begin
				v_s1 <= 1'b1;
			end else if (drain) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			corr_s1     <= mid_data.corr;
			aprod_s1    <= mid_data.corr * $signed({1'b0, RAD_TO_DEG_Q16});
			peak_abs_s1 <= pk_new;
			peak_chg_s1 <= pd_new;
			done_s1     <= last;
		end
	end

	assign a_neg = aprod_s1[45];
	assign a_mag = a_neg ? 46'(-aprod_s1) : 46'(aprod_s1);
	assign a_q   = 30'((a_mag + 46'(ROUND_HALF)) >> 16);

	assign out_push               = drain;
	assign out_data.accel_g       = corr_s1;
	assign out_data.angle_deg     = a_neg ? -29'(a_q) : 29'(a_q);
	assign out_data.peak_abs_g    = peak_abs_s1;
	assign out_data.peak_change_g = peak_chg_s1;
	assign out_data.average_g     = done_s1 ? stat.avg_c : held_c_q;
	assign out_data.raw_average_g = done_s1 ? stat.avg_r : held_r_q;
	assign out_data.block_done    = done_s1;

endmodule

// File: hdl/accel_scale_peak_block_average.sv
// ----------------------------------------------------------------------------
// accel_scale_peak_block_average
// Accelerometer conditioner: scaling, offset and gain correction, tilt angle,
// peak tracking and block averages.
//
// Input side is a queue: a raw sample is taken when push is high and full is
// low. Result side is a queue: while empty is low the oldest result is on the
// result ports, and pop with empty low takes it. Registers are written with
// cfg_we, cfg_index and cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce. A request passes the
// front pipeline, middle queue, back end and output queue to the ports. A new
// request is taken every cycle while full is low; the sample closing a block
// holds the back end while both averages are formed by reciprocal multiplication.
// When the receiver stalls, results collect in the output queue, then the
// middle queue, then the front pipeline, and full rises.
// Reset clears all queues, peaks, sums and averages and loads the register
// reset values; the first sample after reset updates no change peak.
// ----------------------------------------------------------------------------
module accel_scale_peak_block_average import aspba_pkg::*; #(
	parameter int BLOCK_LENGTH = BLOCK_LENGTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  logic signed [15:0]    raw_sample,
	output logic                  empty,
	input  logic                  pop,
	output logic signed [23:0]    accel_g,
	output logic signed [28:0]    angle_deg,
	output logic [22:0]           peak_abs_g,
	output logic [23:0]           peak_change_g,
	output logic signed [23:0]    average_g,
	output logic signed [21:0]    raw_average_g,
	output logic                  block_done
);

	logic      mid_push, mid_full, mid_pop, mid_empty;
	mid_item_t mid_in, mid_out;
	logic      out_push, out_full;
	out_item_t out_in, out_item;

	aspba_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.raw_sample(raw_sample),
		.mid_push  (mid_push),
		.mid_data  (mid_in),
		.mid_full  (mid_full)
	);

	aspba_fifo #(
		.WIDTH($bits(mid_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.din   (mid_in),
		.full  (mid_full),
		.pop   (mid_pop),
		.dout  (mid_out),
		.empty (mid_empty)
	);

	aspba_back #(
		.BLOCK_LENGTH(BLOCK_LENGTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_empty(mid_empty),
		.mid_data (mid_out),
		.mid_pop  (mid_pop),
		.out_push (out_push),
		.out_data (out_in),
		.out_full (out_full)
	);

	aspba_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.din   (out_in),
		.full  (out_full),
		.pop   (pop),
		.dout  (out_item),
		.empty (empty)
	);

	assign accel_g       = out_item.accel_g;
	assign angle_deg     = out_item.angle_deg;
	assign peak_abs_g    = out_item.peak_abs_g;
	assign peak_change_g = out_item.peak_change_g;
	assign average_g     = out_item.average_g;
	assign raw_average_g = out_item.raw_average_g;
	assign block_done    = out_item.block_done;

endmodule

// File: sim/accel_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accel_result_checker
// Watches the register port and both queue sides of the accelerometer
// conditioner. For every accepted request it forms the expected result from
// its own copy of the registers, peaks, sums and averages. Each popped result
// is compared field by field with the oldest expected one. Mismatches and
// unexpected results are counted and reported.
// ----------------------------------------------------------------------------
module accel_result_checker import aspba_pkg::*; #(
	parameter int BLOCK_LENGTH = BLOCK_LENGTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	input  logic                  full,
	input  logic signed [15:0]    raw_sample,
	input  logic                  empty,
	input  logic                  pop,
	input  logic signed [23:0]    accel_g,
	input  logic signed [28:0]    angle_deg,
	input  logic [22:0]           peak_abs_g,
	input  logic [23:0]           peak_change_g,
	input  logic signed [23:0]    average_g,
	input  logic signed [21:0]    raw_average_g,
	input  logic                  block_done,
	output int                    fail_count,
	output int                    pending
);

	localparam longint Q16_ONE = 65536;

	logic [4:0]         full_scale;
	logic signed [21:0] offset;
	logic [17:0]        gain;

	longint prev_corr;
	bit     have_prev;
	longint peak_mag;
	longint peak_delta;
	int     block_count;
	longint corr_sum;
	longint scaled_sum;
	longint avg_corr;
	longint avg_scaled;

	out_item_t expected_results[$];

	// round to nearest, ties away from zero
	function automatic longint round_near(longint num, longint den);
		longint mag;
		mag = (num < 0) ? -num : num;
		mag = (mag + den / 2) / den;
		return (num < 0) ? -mag : mag;
	endfunction

	function automatic out_item_t condition_sample(logic signed [15:0] raw);
		longint    scale;
		longint    scaled;
		longint    corr;
		longint    angle;
		longint    mag;
		bit        done;
		out_item_t res;
		scale = (full_scale > FULL_SCALE_MAX) ? longint'(FULL_SCALE_MAX) : longint'(full_scale);
		scaled = longint'(raw) * scale * 2;
		corr = round_near((scaled - longint'(offset)) * longint'(gain), Q16_ONE);
		if (corr > longint'(ACCEL_LIMIT))
			corr = longint'(ACCEL_LIMIT);
		if (corr < -longint'(ACCEL_LIMIT))
			corr = -longint'(ACCEL_LIMIT);
		angle = round_near(corr * longint'(RAD_TO_DEG_Q16), Q16_ONE);

		mag = (corr < 0) ? -corr : corr;
		if (mag > peak_mag)
			peak_mag = mag;
		if (have_prev) begin
			mag = (corr - prev_corr < 0) ? prev_corr - corr : corr - prev_corr;
			if (mag > peak_delta)
				peak_delta = mag;
		end
		prev_corr = corr;
		have_prev = 1'b1;

		corr_sum += corr;
		scaled_sum += scaled;
		block_count++;
		done = 1'b0;
		if (block_count >= BLOCK_LENGTH) begin
			avg_corr = round_near(corr_sum, longint'(BLOCK_LENGTH));
			avg_scaled = round_near(scaled_sum, longint'(BLOCK_LENGTH));
			corr_sum = 0;
			scaled_sum = 0;
			block_count = 0;
			done = 1'b1;
		end

		res.accel_g = corr[23:0];
		res.angle_deg = angle[28:0];
		res.peak_abs_g = peak_mag[22:0];
		res.peak_change_g = peak_delta[23:0];
		res.average_g = avg_corr[23:0];
		res.raw_average_g = avg_scaled[21:0];
		res.block_done = done;
		return res;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			full_scale = FULL_SCALE_RESET;
			offset = '0;
			gain = GAIN_RESET;
			prev_corr = 0;
			have_prev = 1'b0;
			peak_mag = 0;
			peak_delta = 0;
			block_count = 0;
			corr_sum = 0;
			scaled_sum = 0;
			avg_corr = 0;
			avg_scaled = 0;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FULL_SCALE: full_scale = cfg_data[4:0];
					REG_OFFSET:     offset = cfg_data;
					REG_GAIN:       gain = cfg_data[17:0];
					default:        ;
				endcase
			end
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$display("%0t: expected no result, got accel_g %0d", $time, accel_g);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("accel_g", want.accel_g, accel_g);
					check_field("angle_deg", want.angle_deg, angle_deg);
					check_field("peak_abs_g", want.peak_abs_g, peak_abs_g);
					check_field("peak_change_g", want.peak_change_g, peak_change_g);
					check_field("average_g", want.average_g, average_g);
					check_field("raw_average_g", want.raw_average_g, raw_average_g);
					check_field("block_done", want.block_done, block_done);
				end
			end
			if (push && !full)
				expected_results.push_back(condition_sample(raw_sample));
			pending = expected_results.size();
		end
	end

endmodule

// File: sim/tb_accel_scale_peak_block_average.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_accel_scale_peak_block_average
// Drives the accelerometer conditioner with directed samples under extreme
// register settings, then with random samples over several random settings,
// sent in bursts while the result side stalls in changing patterns. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_accel_scale_peak_block_average import aspba_pkg::*; ();

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_SAMPLES = 80;
	localparam int TAIL_CYCLES   = 64;

	typedef enum logic [1:0] {
		DRAIN_ALL,
		DRAIN_HALF,
		DRAIN_RARE,
		DRAIN_PULSED
	} drain_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  push;
	logic                  full;
	logic signed [15:0]    raw_sample;
	logic                  empty;
	logic                  pop;
	logic signed [23:0]    accel_g;
	logic signed [28:0]    angle_deg;
	logic [22:0]           peak_abs_g;
	logic [23:0]           peak_change_g;
	logic signed [23:0]    average_g;
	logic signed [21:0]    raw_average_g;
	logic                  block_done;

	int          fail_count;
	int          pending;
	int          cycle_count = 0;
	int          drain_tick = 0;
	int          burst_left = 0;
	drain_mode_t drain_mode = DRAIN_ALL;

	accel_scale_peak_block_average #(
		.BLOCK_LENGTH(BLOCK_LENGTH_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.raw_sample(raw_sample),
		.empty(empty),
		.pop(pop),
		.accel_g(accel_g),
		.angle_deg(angle_deg),
		.peak_abs_g(peak_abs_g),
		.peak_change_g(peak_change_g),
		.average_g(average_g),
		.raw_average_g(raw_average_g),
		.block_done(block_done)
	);

	accel_result_checker #(
		.BLOCK_LENGTH(BLOCK_LENGTH_DEF)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.raw_sample(raw_sample),
		.empty(empty),
		.pop(pop),
		.accel_g(accel_g),
		.angle_deg(angle_deg),
		.peak_abs_g(peak_abs_g),
		.peak_change_g(peak_change_g),
		.average_g(average_g),
		.raw_average_g(raw_average_g),
		.block_done(block_done),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side stall pattern, switching mode now and then
	always @(negedge clk) begin
		drain_tick++;
		if (drain_tick % 150 == 0)
			drain_mode = drain_mode_t'($urandom_range(0, 3));
		case (drain_mode)
			DRAIN_ALL:    pop <= 1'b1;
			DRAIN_HALF:   pop <= 1'($urandom_range(0, 1));
			DRAIN_RARE:   pop <= ($urandom_range(0, 7) == 0);
			DRAIN_PULSED: pop <= ((drain_tick % 8) < 3);
			default:      pop <= 1'b1;
		endcase
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_config(input logic [4:0] fs, input logic [21:0] off, input logic [17:0] gn);
		write_reg(REG_FULL_SCALE, CFG_DATA_W'(fs));
		write_reg(REG_OFFSET, off);
		write_reg(REG_GAIN, CFG_DATA_W'(gn));
	endtask

	task automatic send_sample(input logic signed [15:0] v);
		@(negedge clk);
		push <= 1'b1;
		raw_sample <= v;
		do @(posedge clk); while (full);
	endtask

	task automatic pause_requests(input int n);
		repeat (n) begin
			@(negedge clk);
			push <= 1'b0;
		end
	endtask

	// wait until every request has its result back
	task automatic drain;
		pause_requests(1);
		wait (pending == 0);
	endtask

	task automatic probe_extremes(input logic signed [15:0] v);
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		send_sample(v);
	endtask

	function automatic logic signed [15:0] random_sample();
		case ($urandom_range(0, 9))
			0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1, 2:    return 16'($urandom_range(0, 400)) - 16'sd200;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [4:0]  fs;
		logic [21:0] off;
		logic [17:0] gn;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		push = 1'b0;
		raw_sample = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings, first sample has no change
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		send_sample(16'sd0);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_sample(16'sh5555);
		send_sample(16'shAAAA);
		send_sample(16'sd100);

		drain();
		load_config(5'd16, 22'd0, 18'd131072);
		probe_extremes(16'sd12345);
		// full scale above sixteen, zero gain
		drain();
		load_config(5'd31, 22'h300000, 18'd0);
		probe_extremes(-16'sd1);
		// zero full scale
		drain();
		load_config(5'd0, 22'h100000, 18'd65536);
		probe_extremes(16'sd7);
		// odd full scale, widest positive offset and gain
		drain();
		load_config(5'd1, 22'h1FFFFF, 18'h3FFFF);
		probe_extremes(-16'sd300);
		drain();
		load_config(5'd5, 22'h200000, 18'd65536);
		probe_extremes(16'sd2000);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain();
			if ($urandom_range(0, 3) == 0)
				fs = 5'($urandom_range(0, 31));
			else
				fs = 5'd2 << $urandom_range(0, 3);
			if ($urandom_range(0, 3) == 0)
				off = 22'($urandom);
			else
				off = 22'(int'($urandom_range(0, 2097152)) - 1048576);
			if ($urandom_range(0, 3) == 0)
				gn = 18'($urandom);
			else
				gn = 18'($urandom_range(0, 131072));
			load_config(fs, off, gn);
			for (int i = 0; i < PHASE_SAMPLES; i++) begin
				if (burst_left == 0) begin
					pause_requests(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
					burst_left = $urandom_range(1, 40);
				end
				burst_left--;
				send_sample(random_sample());
			end
		end

		drain();
		// room for a late block average or a stray result
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
